// ===== design/tlaf_pkg.sv =====
`timescale 1ns / 1ps

package tlaf_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;
  localparam int TAIL_MAX    = 4;
  localparam int TAIL_LEN_W  = 3;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [CFG_INDEX_W-1:0] REG_NUMBER_MODE      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SQUEEZE_BLANK    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SHOW_ENDS        = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SHOW_TABS        = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SHOW_NONPRINTING = 3'd4;

  localparam logic [1:0] NUM_NONE = 2'd0;
  localparam logic [1:0] NUM_ALL  = 2'd1;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_CTRL   = 8'h40;
  localparam logic [3:0] DIGIT_HI  = 4'h3;

  typedef struct packed {
    logic [1:0] number_mode;
    logic       squeeze_blank;
    logic       show_ends;
    logic       show_tabs;
    logic       show_nonprinting;
  } tlaf_cfg_t;

  typedef struct packed {
    logic                           has_num;
    logic [TAIL_LEN_W-1:0]          len;
    logic [TAIL_MAX-1:0][7:0]       bytes;
  } tlaf_tail_t;

  typedef struct packed {
    logic full;
    logic valid;
  } tlaf_qstat_t;

endpackage

// ===== design/tlaf_front.sv =====
`timescale 1ns / 1ps

module tlaf_front #(
  parameter int NUMBER_DIGITS = 6
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tlaf_pkg::tlaf_cfg_t         cfg,
  input  logic                        in_valid,
  input  logic [7:0]                  in_data_byte,
  input  logic                        in_file_start,
  input  logic                        q_full,
  output logic                        push,
  output tlaf_pkg::tlaf_tail_t        push_tail,
  output logic [4*NUMBER_DIGITS-1:0]  push_bcd
);
  import tlaf_pkg::*;

  localparam int BCD_W = 4 * NUMBER_DIGITS;

  logic             at_line_start_r, at_line_start_nxt;
  logic             blank_seen_r, blank_seen_nxt;
  logic [BCD_W-1:0] line_number_r, line_number_nxt;

  logic             accept;
  logic             als, bs, squeezed, number_it, is_nl;
  logic [BCD_W-1:0] ln, ln_inc;
  logic             all_nine, carry;
  logic [6:0]       lo;
  logic             ctrl;
  logic [7:0]       caret_ch;

  assign accept = in_valid && !q_full;
  assign is_nl  = (in_data_byte == CH_NL);
  assign als    = in_file_start || at_line_start_r;
  assign bs     = in_file_start ? 1'b0 : blank_seen_r;
  assign ln     = in_file_start ? '0 : line_number_r;

  always_comb begin
    all_nine = 1'b1;
    carry    = 1'b1;
    ln_inc   = ln;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (ln[4*i +: 4] != 4'd9) all_nine = 1'b0;
    end
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (carry) begin
        if (ln[4*i +: 4] >= 4'd9) begin
          ln_inc[4*i +: 4] = 4'd0;
        end else begin
          ln_inc[4*i +: 4] = ln[4*i +: 4] + 4'd1;
          carry = 1'b0;
        end
      end
    end
    if (all_nine) ln_inc = ln;
  end

  always_comb begin
    squeezed          = als && cfg.squeeze_blank && is_nl && bs;
    number_it         = als && ((cfg.number_mode == NUM_ALL) ||
                                (cfg.number_mode[1] && !is_nl));
    blank_seen_nxt    = (als && cfg.squeeze_blank) ? is_nl : bs;
    line_number_nxt   = number_it ? ln_inc : ln;
    at_line_start_nxt = is_nl;
    if (squeezed) begin
      blank_seen_nxt    = 1'b1;
      line_number_nxt   = ln;
      at_line_start_nxt = 1'b1;
    end
  end

  assign lo       = in_data_byte[6:0];
  assign ctrl     = (lo < 7'h20) || (lo == CH_DEL[6:0]);
  assign caret_ch = (lo == CH_DEL[6:0]) ? CH_QMARK : ({1'b0, lo} | CH_CTRL);

  always_comb begin
    push_tail         = '0;
    push_tail.has_num = number_it;
    push_tail.len     = TAIL_LEN_W'(1);
    push_tail.bytes[0] = in_data_byte;
    if (is_nl) begin
      if (cfg.show_ends) begin
        push_tail.len      = TAIL_LEN_W'(2);
        push_tail.bytes[0] = CH_DOLLAR;
        push_tail.bytes[1] = CH_NL;
      end
    end else if (in_data_byte == CH_TAB) begin
      if (cfg.show_tabs) begin
        push_tail.len      = TAIL_LEN_W'(2);
        push_tail.bytes[0] = CH_CARET;
        push_tail.bytes[1] = CH_I;
      end
    end else if (cfg.show_nonprinting) begin
      case ({in_data_byte[7], ctrl})
        2'b11: begin
          push_tail.len      = TAIL_LEN_W'(4);
          push_tail.bytes[0] = CH_M;
          push_tail.bytes[1] = CH_DASH;
          push_tail.bytes[2] = CH_CARET;
          push_tail.bytes[3] = caret_ch;
        end
        2'b10: begin
          push_tail.len      = TAIL_LEN_W'(3);
          push_tail.bytes[0] = CH_M;
          push_tail.bytes[1] = CH_DASH;
          push_tail.bytes[2] = {1'b0, lo};
        end
        2'b01: begin
          push_tail.len      = TAIL_LEN_W'(2);
          push_tail.bytes[0] = CH_CARET;
          push_tail.bytes[1] = caret_ch;
        end
        default: begin
          push_tail.bytes[0] = in_data_byte;
        end
      endcase
    end
  end

  assign push     = accept && !squeezed;
  assign push_bcd = ln_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_line_start_r <= 1'b1;
      blank_seen_r    <= 1'b0;
      line_number_r   <= '0;
    end else if (accept) begin
      at_line_start_r <= at_line_start_nxt;
      blank_seen_r    <= blank_seen_nxt;
      line_number_r   <= line_number_nxt;
    end
  end

endmodule

// ===== design/tlaf_queue.sv =====
`timescale 1ns / 1ps

module tlaf_queue #(
  parameter int NUMBER_DIGITS = 6
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  tlaf_pkg::tlaf_tail_t        push_tail,
  input  logic [4*NUMBER_DIGITS-1:0]  push_bcd,
  input  logic                        pop,
  output tlaf_pkg::tlaf_qstat_t       stat,
  output tlaf_pkg::tlaf_tail_t        head_tail,
  output logic [4*NUMBER_DIGITS-1:0]  head_bcd
);
  import tlaf_pkg::*;

  tlaf_tail_t                 tail_r [QDEPTH];
  logic [4*NUMBER_DIGITS-1:0] bcd_r  [QDEPTH];
  logic [QPTR_W-1:0]          wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]          count_r, count_nxt;

  assign stat.full  = (count_r == QCNT_W'(QDEPTH));
  assign stat.valid = (count_r != '0);
  assign head_tail  = tail_r[rd_ptr_r];
  assign head_bcd   = bcd_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + QCNT_W'(1);
      2'b01:   count_nxt = count_r - QCNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      tail_r[wr_ptr_r] <= push_tail;
      bcd_r[wr_ptr_r]  <= push_bcd;
    end
  end

endmodule

// ===== design/tlaf_back.sv =====
`timescale 1ns / 1ps

module tlaf_back #(
  parameter int NUMBER_DIGITS = 6
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  tlaf_pkg::tlaf_tail_t        head_tail,
  input  logic [4*NUMBER_DIGITS-1:0]  head_bcd,
  output logic                        pop,
  output logic                        out_valid,
  output logic [7:0]                  out_byte,
  output logic                        out_last,
  input  logic                        out_stall
);
  import tlaf_pkg::*;

  localparam int IDX_W = $clog2(NUMBER_DIGITS + TAIL_MAX + 1);

  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic                     out_valid_r;
  logic [7:0]               out_byte_r, byte_nxt;
  logic                     out_last_r, last_nxt;
  logic                     load;
  logic [IDX_W-1:0]         num_len, total, tail_idx;
  logic [NUMBER_DIGITS-1:0] lz;
  logic                     run;

  assign load     = q_valid && (!out_valid_r || !out_stall);
  assign num_len  = head_tail.has_num ? IDX_W'(NUMBER_DIGITS + 1) : '0;
  assign total    = num_len + IDX_W'(head_tail.len);
  assign tail_idx = idx_r - num_len;
  assign last_nxt = (idx_r == total - IDX_W'(1));
  assign pop      = load && last_nxt;
  assign idx_nxt  = last_nxt ? '0 : idx_r + IDX_W'(1);

  always_comb begin
    run = 1'b1;
    lz  = '0;
    for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
      run   = run && (head_bcd[4*i +: 4] == 4'd0);
      lz[i] = run;
    end
  end

  always_comb begin
    byte_nxt = head_tail.bytes[tail_idx[1:0]];
    if (head_tail.has_num) begin
      if (idx_r == IDX_W'(NUMBER_DIGITS)) byte_nxt = CH_TAB;
      for (int p = 0; p < NUMBER_DIGITS; p++) begin
        if (idx_r == IDX_W'(p)) begin
          if (lz[NUMBER_DIGITS-1-p] && (p != NUMBER_DIGITS - 1)) begin
            byte_nxt = CH_SPACE;
          end else begin
            byte_nxt = {DIGIT_HI, head_bcd[4*(NUMBER_DIGITS-1-p) +: 4]};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r       <= idx_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= byte_nxt;
      out_last_r <= last_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

// ===== design/text_line_annotate_filter_unit.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_stall   in_data_byte, in_file_start
// out_     output     out_valid/out_stall out_byte, out_last
// cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One input byte is taken per cycle while the four-entry queue has room.
// Each byte yields 1 to NUMBER_DIGITS+5 output beats, one per cycle while out_stall
// is low, set by the back-end serializer; a squeezed blank line yields none.
// rst_n is synchronous: line state, queue and output valid flag clear.
// in_stall rises when the queue is full; out_stall holds the output register.

module text_line_annotate_filter_unit #(
  parameter int NUMBER_DIGITS = 6
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_data_byte,
  input  logic                            in_file_start,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_byte,
  output logic                            out_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tlaf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tlaf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tlaf_pkg::*;

  tlaf_cfg_t                  cfg_r;
  tlaf_qstat_t                qstat;
  tlaf_tail_t                 push_tail, head_tail;
  logic [4*NUMBER_DIGITS-1:0] push_bcd, head_bcd;
  logic                       push, pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = qstat.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NUMBER_MODE:      cfg_r.number_mode      <= cfg_data[1:0];
        REG_SQUEEZE_BLANK:    cfg_r.squeeze_blank    <= cfg_data[0];
        REG_SHOW_ENDS:        cfg_r.show_ends        <= cfg_data[0];
        REG_SHOW_TABS:        cfg_r.show_tabs        <= cfg_data[0];
        REG_SHOW_NONPRINTING: cfg_r.show_nonprinting <= cfg_data[0];
        default:              cfg_r                  <= cfg_r;
      endcase
    end
  end

  tlaf_front #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_data_byte  (in_data_byte),
    .in_file_start (in_file_start),
    .q_full        (qstat.full),
    .push          (push),
    .push_tail     (push_tail),
    .push_bcd      (push_bcd)
  );

  tlaf_queue #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_tail (push_tail),
    .push_bcd  (push_bcd),
    .pop       (pop),
    .stat      (qstat),
    .head_tail (head_tail),
    .head_bcd  (head_bcd)
  );

  tlaf_back #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (qstat.valid),
    .head_tail (head_tail),
    .head_bcd  (head_bcd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .out_stall (out_stall)
  );

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && qstat.full))
    else $error("queue written while full");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> qstat.valid)
    else $error("queue popped while empty");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !qstat.valid) |=> !out_valid)
    else $error("output beat without queued work");

  a_first_line: assert property (@(posedge clk) disable iff (!rst_n)
    (push && in_file_start && cfg_r.number_mode == NUM_ALL) |->
      (push_bcd == (4*NUMBER_DIGITS)'(1)))
    else $error("line number not restarted at file start");
`endif

endmodule
